// File: rtl/psf_pkg.sv
// ----------------------------------------------------------------------------
// psf_pkg
// Shared constants, payload types and helpers for the pair sum index finder.
// ----------------------------------------------------------------------------
`default_nettype none

package psf_pkg;

    localparam int STORE_DEPTH = 64;
    localparam int DATA_W      = 32;
    localparam int ADDR_W      = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;
    localparam int CNT_W       = $clog2(STORE_DEPTH + 1);
    localparam int OUT_IDX_W   = 6;
    localparam int STATUS_W    = 2;

    localparam logic [STATUS_W-1:0] ST_PAIR = 2'd0;
    localparam logic [STATUS_W-1:0] ST_NONE = 2'd1;
    localparam logic [STATUS_W-1:0] ST_LONG = 2'd2;

    typedef struct packed {
        logic signed [DATA_W-1:0] element;
        logic                     last_element;
    } in_t;

    typedef struct packed {
        logic [STATUS_W-1:0]  status;
        logic [OUT_IDX_W-1:0] first_index;
        logic [OUT_IDX_W-1:0] second_index;
    } out_t;

    // reduce an element index to the reported index width
    function automatic logic [OUT_IDX_W-1:0] to_out_idx(input logic [CNT_W-1:0] v);
        logic [CNT_W+OUT_IDX_W-1:0] wide;
        wide = {{OUT_IDX_W{1'b0}}, v};
        return wide[OUT_IDX_W-1:0];
    endfunction

endpackage

`default_nettype wire

// File: rtl/psf_store.sv
// ----------------------------------------------------------------------------
// psf_store
// Element value store: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
`default_nettype none

module psf_store
    import psf_pkg::*;
(
    input  wire logic              aclk,
    input  wire logic              wr_en,
    input  wire logic [ADDR_W-1:0] wr_addr,
    input  wire logic [DATA_W-1:0] wr_data,
    input  wire logic              rd_en,
    input  wire logic [ADDR_W-1:0] rd_addr,
    output logic      [DATA_W-1:0] rd_data
);

    logic [DATA_W-1:0] mem [STORE_DEPTH];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

`default_nettype wire

// File: rtl/psf_cmp.sv
// ----------------------------------------------------------------------------
// psf_cmp
// Shared compare unit: holds target minus element in 33-bit arithmetic and
// matches it against one stored value per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module psf_cmp
    import psf_pkg::*;
(
    input  wire logic              aclk,
    input  wire logic              load,
    input  wire logic [DATA_W-1:0] target,
    input  wire logic [DATA_W-1:0] element,
    input  wire logic [DATA_W-1:0] cand,
    output logic                   hit
);

    logic [DATA_W:0] rem_reg;

    always_ff @(posedge aclk) begin
        if (load) begin
            rem_reg <= {target[DATA_W-1], target} - {element[DATA_W-1], element};
        end
    end

    assign hit = ({cand[DATA_W-1], cand} == rem_reg);

endmodule

`default_nettype wire

// File: rtl/pair_sum_index_finder.sv
// Timing: an element is accepted in S_IDLE, then S_SCAN reads the stored entries from the
//   newest down and compares each; a result passes S_EMIT before it is on m_.
// Throughput: s_ready is low outside S_IDLE, so a new element waits until the last is
//   done; set by the single store read port feeding the one comparator.
// Reset: synchronous, active low; clears control state and target_reg to 0.
//   Store contents are not cleared; the fill count marks which entries hold data.
// ----------------------------------------------------------------------------
// pair_sum_index_finder
// Two-sum search over a stream of array elements with a scanned value store.
// ----------------------------------------------------------------------------
`default_nettype none

module pair_sum_index_finder
    import psf_pkg::*;
(
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              s_valid,
    output logic                   s_ready,
    input  wire in_t               s_data,
    output logic                   m_valid,
    input  wire logic              m_ready,
    output out_t                   m_data,
    input  wire logic              cfg_wr_en,
    input  wire logic [DATA_W-1:0] cfg_wr_data
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_EMIT
    } state_t;

    state_t            state_reg, state_next;
    logic [DATA_W-1:0] target_reg;
    logic [DATA_W-1:0] elem_reg, elem_next;
    logic              last_reg, last_next;
    logic [CNT_W-1:0]  count_reg, count_next;
    logic              pair_reg, pair_next;
    logic              ovf_reg, ovf_next;
    logic [ADDR_W-1:0] addr_reg, addr_next;
    logic              issue_reg, issue_next;
    logic              chk_valid_reg, chk_valid_next;
    logic [ADDR_W-1:0] chk_addr_reg, chk_addr_next;
    out_t              res_reg, res_next;
    logic              m_valid_reg, m_valid_next;
    out_t              m_data_reg, m_data_next;

    logic              wr_en;
    logic [ADDR_W-1:0] wr_addr;
    logic [DATA_W-1:0] wr_data;
    logic              rd_en;
    logic [DATA_W-1:0] rd_data;
    logic              cmp_load;
    logic              hit;

    psf_store u_store (
        .aclk    (aclk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (addr_reg),
        .rd_data (rd_data)
    );

    psf_cmp u_cmp (
        .aclk    (aclk),
        .load    (cmp_load),
        .target  (target_reg),
        .element (s_data.element),
        .cand    (rd_data),
        .hit     (hit)
    );

    assign s_ready = (state_reg == S_IDLE);
    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;
    assign rd_en   = (state_reg == S_SCAN) && issue_reg;

    always_comb begin
        state_next     = state_reg;
        elem_next      = elem_reg;
        last_next      = last_reg;
        count_next     = count_reg;
        pair_next      = pair_reg;
        ovf_next       = ovf_reg;
        addr_next      = addr_reg;
        issue_next     = issue_reg;
        chk_valid_next = chk_valid_reg;
        chk_addr_next  = chk_addr_reg;
        res_next       = res_reg;
        m_valid_next   = m_valid_reg && !m_ready;
        m_data_next    = m_data_reg;
        wr_en          = 1'b0;
        wr_addr        = ADDR_W'(count_reg);
        wr_data        = elem_reg;
        cmp_load       = 1'b0;

        unique case (state_reg)
            S_IDLE: begin
                if (s_valid) begin
                    elem_next = s_data.element;
                    last_next = s_data.last_element;
                    cmp_load  = 1'b1;
                    if (pair_reg) begin
                        if (s_data.last_element) begin
                            count_next = '0;
                            pair_next  = 1'b0;
                            ovf_next   = 1'b0;
                        end
                    end else if (count_reg == CNT_W'(STORE_DEPTH)) begin
                        ovf_next = 1'b1;
                        if (s_data.last_element) begin
                            res_next   = '{status: ST_LONG, first_index: '0, second_index: '0};
                            count_next = '0;
                            ovf_next   = 1'b0;
                            state_next = S_EMIT;
                        end
                    end else if (count_reg == '0) begin
                        wr_en      = 1'b1;
                        wr_data    = s_data.element;
                        count_next = CNT_W'(1);
                        if (s_data.last_element) begin
                            res_next   = '{status: ST_NONE, first_index: '0, second_index: '0};
                            count_next = '0;
                            ovf_next   = 1'b0;
                            state_next = S_EMIT;
                        end
                    end else begin
                        addr_next      = ADDR_W'(count_reg - CNT_W'(1));
                        issue_next     = 1'b1;
                        chk_valid_next = 1'b0;
                        state_next     = S_SCAN;
                    end
                end
            end
            S_SCAN: begin
                chk_valid_next = issue_reg;
                chk_addr_next  = addr_reg;
                if (issue_reg) begin
                    if (addr_reg == '0) begin
                        issue_next = 1'b0;
                    end else begin
                        addr_next = addr_reg - ADDR_W'(1);
                    end
                end
                if (chk_valid_reg) begin
                    if (hit) begin
                        res_next = '{status: ST_PAIR,
                                     first_index: to_out_idx(CNT_W'(chk_addr_reg)),
                                     second_index: to_out_idx(count_reg)};
                        issue_next     = 1'b0;
                        chk_valid_next = 1'b0;
                        state_next     = S_EMIT;
                        if (last_reg) begin
                            count_next = '0;
                            pair_next  = 1'b0;
                            ovf_next   = 1'b0;
                        end else begin
                            pair_next = 1'b1;
                        end
                    end else if (chk_addr_reg == '0) begin
                        wr_en          = 1'b1;
                        count_next     = count_reg + CNT_W'(1);
                        issue_next     = 1'b0;
                        chk_valid_next = 1'b0;
                        state_next     = S_IDLE;
                        if (last_reg) begin
                            res_next   = '{status: (ovf_reg ? ST_LONG : ST_NONE),
                                           first_index: '0, second_index: '0};
                            count_next = '0;
                            ovf_next   = 1'b0;
                            state_next = S_EMIT;
                        end
                    end
                end
            end
            S_EMIT: begin
                if (!m_valid_reg || m_ready) begin
                    m_valid_next = 1'b1;
                    m_data_next  = res_reg;
                    state_next   = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= S_IDLE;
            target_reg    <= '0;
            count_reg     <= '0;
            pair_reg      <= 1'b0;
            ovf_reg       <= 1'b0;
            issue_reg     <= 1'b0;
            chk_valid_reg <= 1'b0;
            m_valid_reg   <= 1'b0;
        end else begin
            state_reg     <= state_next;
            if (cfg_wr_en) begin
                target_reg <= cfg_wr_data;
            end
            count_reg     <= count_next;
            pair_reg      <= pair_next;
            ovf_reg       <= ovf_next;
            issue_reg     <= issue_next;
            chk_valid_reg <= chk_valid_next;
            m_valid_reg   <= m_valid_next;
        end
        elem_reg     <= elem_next;
        last_reg     <= last_next;
        addr_reg     <= addr_next;
        chk_addr_reg <= chk_addr_next;
        res_reg      <= res_next;
        m_data_reg   <= m_data_next;
    end

    // fill count never passes the store depth
    assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CNT_W'(STORE_DEPTH))
        else $error("fill count beyond store depth");

    // a scan only runs on a partly filled store
    assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_SCAN) |-> (count_reg != '0) && (count_reg < CNT_W'(STORE_DEPTH)))
        else $error("scan with empty or full store");

    // checked entry always lies below the fill count
    assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_SCAN) && chk_valid_reg |-> (CNT_W'(chk_addr_reg) < count_reg))
        else $error("checked entry not filled");

    // once a pair is reported no overflow can be flagged in the same array
    assert property (@(posedge aclk) disable iff (!aresetn)
        pair_reg |-> !ovf_reg)
        else $error("overflow after reported pair");

    // only a found pair carries indices
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_data.status != ST_PAIR) |->
            (m_data.first_index == '0) && (m_data.second_index == '0))
        else $error("indices on a no-pair transaction");

endmodule

`default_nettype wire
